/* design/ok2rgb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ok2rgb_pkg
// Shared widths, value types and matrix coefficients for the Oklab to
// linear sRGB pipeline.
// ----------------------------------------------------------------------------
package ok2rgb_pkg;

    // Fraction bits of the pixel components (Q2.14 at the default).
    localparam int FRAC_BITS  = 14;
    // Fraction bits of the matrix coefficients.
    localparam int COEF_BITS  = 30;

    localparam int COMP_W     = 16;
    // l', m', s' in pixel units: |L| + |a| + |b| scaled stays below 2^17.
    localparam int P_W        = 18;
    localparam int SQ_W       = 2 * P_W;
    localparam int PC_W       = 3 * P_W;
    localparam int CUBE_W     = PC_W - 2 * FRAC_BITS;

    localparam int LMS_COEF_W = 32;
    localparam int LMS_PROD_W = LMS_COEF_W + COMP_W;
    localparam int LMS_ACC_W  = LMS_PROD_W + 2;

    localparam int RGB_COEF_W = 34;
    localparam int RGB_PROD_W = RGB_COEF_W + CUBE_W;
    localparam int RGB_ACC_W  = RGB_PROD_W + 2;
    localparam int RGB_RND_W  = RGB_ACC_W - COEF_BITS;

    typedef logic signed [COMP_W-1:0]     comp_t;
    typedef logic signed [P_W-1:0]        lms_val_t;
    typedef logic signed [CUBE_W-1:0]     cube_val_t;
    typedef logic signed [LMS_COEF_W-1:0] lms_coef_t;
    typedef logic signed [RGB_COEF_W-1:0] rgb_coef_t;

    localparam logic [63:0] DEC_SCALE = 64'd10000000000;

    // Decimal value times 1e10 to Q(COEF_BITS), magnitude rounded half up.
    function automatic logic signed [63:0] to_q(input logic signed [63:0] dec);
        logic [63:0] mag;
        logic [63:0] whole;
        logic [63:0] rem;
        logic [63:0] q;
        mag   = (dec < 0) ? 64'(-dec) : 64'(dec);
        whole = mag / DEC_SCALE;
        rem   = mag % DEC_SCALE;
        q     = (whole << COEF_BITS) + (((rem << COEF_BITS) + DEC_SCALE / 2) / DEC_SCALE);
        return (dec < 0) ? $signed(-q) : $signed(q);
    endfunction

    // a and b weights of l', m', s' (L weight is one).
    localparam lms_coef_t LMS_COEF [3][2] = '{
        '{LMS_COEF_W'(to_q( 64'sd3963377774)),  LMS_COEF_W'(to_q( 64'sd2158037573))},
        '{LMS_COEF_W'(to_q(-64'sd1055613458)),  LMS_COEF_W'(to_q(-64'sd638541728))},
        '{LMS_COEF_W'(to_q(-64'sd894841775)),   LMS_COEF_W'(to_q(-64'sd12914855480))}
    };

    localparam rgb_coef_t RGB_COEF [3][3] = '{
        '{RGB_COEF_W'(to_q( 64'sd40767416621)), RGB_COEF_W'(to_q(-64'sd33077115913)),
          RGB_COEF_W'(to_q( 64'sd2309699292))},
        '{RGB_COEF_W'(to_q(-64'sd12684380046)), RGB_COEF_W'(to_q( 64'sd26097574011)),
          RGB_COEF_W'(to_q(-64'sd3413193965))},
        '{RGB_COEF_W'(to_q(-64'sd41960863)),    RGB_COEF_W'(to_q(-64'sd7034186147)),
          RGB_COEF_W'(to_q( 64'sd17076147010))}
    };

    localparam comp_t COMP_MAX = 16'sh7FFF;
    localparam comp_t COMP_MIN = -16'sh8000;

endpackage : ok2rgb_pkg
`default_nettype wire

/* design/ok2rgb_lms.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ok2rgb_lms
// First matrix: l', m', s' = L + ka*a + kb*b, two register stages
// (products, then sum and round).
// ----------------------------------------------------------------------------
module ok2rgb_lms (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire ok2rgb_pkg::comp_t    lightness,
    input  wire ok2rgb_pkg::comp_t    green_red_axis,
    input  wire ok2rgb_pkg::comp_t    blue_yellow_axis,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output ok2rgb_pkg::lms_val_t      lms_data [3]
);
    import ok2rgb_pkg::*;

    localparam logic signed [LMS_ACC_W-1:0] HALF =
        LMS_ACC_W'(64'sd1 <<< (COEF_BITS - 1));

    logic                          valid1_reg;
    logic                          valid2_reg;
    logic                          adv1;
    logic                          adv2;
    comp_t                         lum_reg;
    logic signed [LMS_PROD_W-1:0]  pa_reg [3];
    logic signed [LMS_PROD_W-1:0]  pb_reg [3];
    logic signed [LMS_PROD_W-1:0]  pa_next [3];
    logic signed [LMS_PROD_W-1:0]  pb_next [3];
    lms_val_t                      p_reg [3];
    lms_val_t                      p_next [3];
    logic signed [LMS_ACC_W-1:0]   acc [3];

    assign adv2     = !valid2_reg || out_ready;
    assign adv1     = !valid1_reg || adv2;
    assign in_ready = adv1;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pa_next[i] = LMS_COEF[i][0] * green_red_axis;
            pb_next[i] = LMS_COEF[i][1] * blue_yellow_axis;
            acc[i]     = LMS_ACC_W'($signed({lum_reg, {COEF_BITS{1'b0}}}))
                       + LMS_ACC_W'(pa_reg[i]) + LMS_ACC_W'(pb_reg[i]) + HALF;
            p_next[i]  = acc[i][COEF_BITS +: P_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end else begin
            if (adv1) begin
                valid1_reg <= in_valid;
            end
            if (adv2) begin
                valid2_reg <= valid1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1 && in_valid) begin
            lum_reg <= lightness;
            pa_reg  <= pa_next;
            pb_reg  <= pb_next;
        end
        if (adv2 && valid1_reg) begin
            p_reg <= p_next;
        end
    end

    assign out_valid = valid2_reg;
    assign lms_data  = p_reg;

endmodule : ok2rgb_lms
`default_nettype wire

/* design/ok2rgb_cube.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ok2rgb_cube
// Cube of each cone response: square, multiply by the value again,
// round back to the pixel fraction bits. Three register stages.
// ----------------------------------------------------------------------------
module ok2rgb_cube (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire ok2rgb_pkg::lms_val_t  lms_data [3],
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output ok2rgb_pkg::cube_val_t      cube_data [3]
);
    import ok2rgb_pkg::*;

    localparam logic signed [PC_W-1:0] HALF = PC_W'(64'sd1 <<< (2 * FRAC_BITS - 1));

    logic                     valid1_reg;
    logic                     valid2_reg;
    logic                     valid3_reg;
    logic                     adv1;
    logic                     adv2;
    logic                     adv3;
    logic signed [SQ_W-1:0]   sq_reg [3];
    logic signed [SQ_W-1:0]   sq_next [3];
    lms_val_t                 p_reg [3];
    logic signed [PC_W-1:0]   pc_reg [3];
    logic signed [PC_W-1:0]   pc_next [3];
    logic signed [PC_W-1:0]   rnd [3];
    cube_val_t                cube_reg [3];
    cube_val_t                cube_next [3];

    assign adv3     = !valid3_reg || out_ready;
    assign adv2     = !valid2_reg || adv3;
    assign adv1     = !valid1_reg || adv2;
    assign in_ready = adv1;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sq_next[i]   = lms_data[i] * lms_data[i];
            pc_next[i]   = sq_reg[i] * p_reg[i];
            rnd[i]       = pc_reg[i] + HALF;
            cube_next[i] = rnd[i][2 * FRAC_BITS +: CUBE_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
        end else begin
            if (adv1) begin
                valid1_reg <= in_valid;
            end
            if (adv2) begin
                valid2_reg <= valid1_reg;
            end
            if (adv3) begin
                valid3_reg <= valid2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1 && in_valid) begin
            sq_reg <= sq_next;
            p_reg  <= lms_data;
        end
        if (adv2 && valid1_reg) begin
            pc_reg <= pc_next;
        end
        if (adv3 && valid2_reg) begin
            cube_reg <= cube_next;
        end
    end

    assign out_valid = valid3_reg;
    assign cube_data = cube_reg;

endmodule : ok2rgb_cube
`default_nettype wire

/* design/ok2rgb_rgb.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ok2rgb_rgb
// Second matrix: linear RGB from the cubed responses. One stage of nine
// products, one stage of sum, round and saturate (the output register).
// ----------------------------------------------------------------------------
module ok2rgb_rgb (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire ok2rgb_pkg::cube_val_t  cube_data [3],
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output ok2rgb_pkg::comp_t           rgb_data [3]
);
    import ok2rgb_pkg::*;

    localparam logic signed [RGB_ACC_W-1:0] HALF =
        RGB_ACC_W'(64'sd1 <<< (COEF_BITS - 1));

    logic                          valid1_reg;
    logic                          valid2_reg;
    logic                          adv1;
    logic                          adv2;
    logic signed [RGB_PROD_W-1:0]  prod_reg [3][3];
    logic signed [RGB_PROD_W-1:0]  prod_next [3][3];
    logic signed [RGB_ACC_W-1:0]   acc [3];
    logic signed [RGB_RND_W-1:0]   rnd [3];
    comp_t                         rgb_reg [3];
    comp_t                         rgb_next [3];

    assign adv2     = !valid2_reg || out_ready;
    assign adv1     = !valid1_reg || adv2;
    assign in_ready = adv1;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                prod_next[i][j] = RGB_COEF[i][j] * cube_data[j];
            end
            acc[i] = RGB_ACC_W'(prod_reg[i][0]) + RGB_ACC_W'(prod_reg[i][1])
                   + RGB_ACC_W'(prod_reg[i][2]) + HALF;
            rnd[i] = acc[i][COEF_BITS +: RGB_RND_W];
            // clamp to the 16-bit signed range
            if (rnd[i] > RGB_RND_W'(COMP_MAX)) begin
                rgb_next[i] = COMP_MAX;
            end else if (rnd[i] < RGB_RND_W'(COMP_MIN)) begin
                rgb_next[i] = COMP_MIN;
            end else begin
                rgb_next[i] = rnd[i][COMP_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end else begin
            if (adv1) begin
                valid1_reg <= in_valid;
            end
            if (adv2) begin
                valid2_reg <= valid1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1 && in_valid) begin
            prod_reg <= prod_next;
        end
        if (adv2 && valid1_reg) begin
            rgb_reg <= rgb_next;
        end
    end

    assign out_valid = valid2_reg;
    assign rgb_data  = rgb_reg;

endmodule : ok2rgb_rgb
`default_nettype wire

/* design/oklab_to_linear_srgb.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oklab_to_linear_srgb
// Oklab pixel to linear sRGB, streaming, one pixel per clock while the output does not stall.
// ----------------------------------------------------------------------------
// Takes one Oklab pixel (L, a, b, signed Q2.14) per beat and returns one
// linear sRGB pixel (signed Q2.14, saturated to 16 bits) per beat, in order.
// Throughput is one pixel per clock when the output side does not stall.
// The seven register stages are: first-matrix products, first-matrix sum
// and round, square, cube, cube round, second-matrix products, and
// sum/round/saturate into the output register. Each stage holds its own
// valid bit and advances when it is empty or the stage after it moves, so
// bubbles close up and a stall on m_axis_tready holds every beat in place;
// s_axis_tready drops only when the whole pipeline is full. No state
// carries from one pixel to the next.
// ----------------------------------------------------------------------------
module oklab_to_linear_srgb (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input pixel stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // lightness, green_red_axis, blue_yellow_axis
    // output pixel stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata    // linear_red, linear_green, linear_blue
);
    import ok2rgb_pkg::*;

    comp_t      lightness;
    comp_t      green_red_axis;
    comp_t      blue_yellow_axis;

    logic       lms_valid;
    logic       lms_ready;
    lms_val_t   lms_data [3];
    logic       cube_valid;
    logic       cube_ready;
    cube_val_t  cube_data [3];
    comp_t      rgb_data [3];

    // unpack the input beat, first field in the lowest bits
    assign lightness        = s_axis_tdata[15:0];
    assign green_red_axis   = s_axis_tdata[31:16];
    assign blue_yellow_axis = s_axis_tdata[47:32];

    // cone responses l', m', s'
    ok2rgb_lms u_lms (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (s_axis_tvalid),
        .in_ready         (s_axis_tready),
        .lightness        (lightness),
        .green_red_axis   (green_red_axis),
        .blue_yellow_axis (blue_yellow_axis),
        .out_valid        (lms_valid),
        .out_ready        (lms_ready),
        .lms_data         (lms_data)
    );

    // cube each response
    ok2rgb_cube u_cube (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (lms_valid),
        .in_ready  (lms_ready),
        .lms_data  (lms_data),
        .out_valid (cube_valid),
        .out_ready (cube_ready),
        .cube_data (cube_data)
    );

    // second matrix, round, saturate; its last stage is the output register
    ok2rgb_rgb u_rgb (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cube_valid),
        .in_ready  (cube_ready),
        .cube_data (cube_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .rgb_data  (rgb_data)
    );

    // pack the output beat: red lowest, then green, then blue
    assign m_axis_tdata = {rgb_data[2], rgb_data[1], rgb_data[0]};

endmodule : oklab_to_linear_srgb
`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level testbench for the Oklab to linear sRGB converter.
// ----------------------------------------------------------------------------
// Drives Oklab pixels into the slave stream and checks every linear sRGB beat
// on the master stream against an in-bench fixed-point model of the two
// matrices and the cube stage, or a typed-in result. A short table of directed
// pixels comes first: zero, white, the field extremes and saturating colors.
// Random pixels follow, mostly natural colors with some full-range noise and
// extreme mixes. Both sides idle at random per beat. A long receiver hold-off
// fills the pipeline, and the sender drains it completely more than once.
// ----------------------------------------------------------------------------
module tb_top;
    import ok2rgb_pkg::*;

    // [0] is the first field: L / red, [1] a / green, [2] b / blue.
    typedef logic [2:0][15:0] pixel_t;

    // One directed pixel; when known is set, the result is typed in.
    typedef struct packed {
        comp_t l;
        comp_t a;
        comp_t b;
        logic  known;
        comp_t red;
        comp_t green;
        comp_t blue;
    } dir_row_t;

    localparam int NUM_DIRECTED = 21;
    localparam int NUM_RANDOM   = 800;
    localparam int MAX_GAP      = 18;
    localparam int RX_HOLD      = 100;
    localparam int BURST_ITEMS  = 40;
    localparam int TAIL_CYCLES  = 20;
    localparam int PIX_FRAC     = 14;
    localparam int MAT_FRAC     = 30;

    // Matrix weights as decimal value times 1e10.
    localparam longint CONE_DEC [3][2] = '{
        '{ 64'sd3963377774,   64'sd2158037573},
        '{-64'sd1055613458,  -64'sd638541728},
        '{-64'sd894841775,   -64'sd12914855480}
    };
    localparam longint RGB_DEC [3][3] = '{
        '{ 64'sd40767416621, -64'sd33077115913,  64'sd2309699292},
        '{-64'sd12684380046,  64'sd26097574011, -64'sd3413193965},
        '{-64'sd41960863,    -64'sd7034186147,   64'sd17076147010}
    };

    localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
        // black and white
        '{0,      0,      0,      1'b1, 0,      0,      0},
        '{16384,  0,      0,      1'b1, 16384,  16384,  16384},
        // lightness extremes saturate every channel
        '{32767,  0,      0,      1'b1, 32767,  32767,  32767},
        '{-32768, 0,      0,      1'b1, -32768, -32768, -32768},
        '{8192,   0,      0,      1'b0, 0,      0,      0},
        // opponent axis extremes
        '{0,      32767,  0,      1'b0, 0,      0,      0},
        '{0,      -32768, 0,      1'b0, 0,      0,      0},
        '{0,      0,      32767,  1'b0, 0,      0,      0},
        '{0,      0,      -32768, 1'b0, 0,      0,      0},
        '{32767,  32767,  32767,  1'b0, 0,      0,      0},
        '{-32768, -32768, -32768, 1'b0, 0,      0,      0},
        '{32767,  -32768, 32767,  1'b0, 0,      0,      0},
        '{-32768, 32767,  -32768, 1'b0, 0,      0,      0},
        // in-gamut and out-of-gamut colors
        '{16384,  3277,   -3277,  1'b0, 0,      0,      0},
        '{10000,  -4000,  2000,   1'b0, 0,      0,      0},
        '{16384,  -6554,  6554,   1'b0, 0,      0,      0},
        '{1,      1,      1,      1'b0, 0,      0,      0},
        '{-1,     -1,     -1,     1'b0, 0,      0,      0},
        '{16384,  0,      -16384, 1'b0, 0,      0,      0},
        '{4096,   8000,   8000,   1'b0, 0,      0,      0},
        '{21845,  -21846, 21845,  1'b0, 0,      0,      0}
    };

    logic   aclk;
    logic   aresetn;
    logic   s_axis_tvalid;
    logic   s_axis_tready;
    pixel_t s_axis_tdata;   // lightness, green_red_axis, blue_yellow_axis
    logic   m_axis_tvalid;
    logic   m_axis_tready;
    pixel_t m_axis_tdata;   // linear_red, linear_green, linear_blue

    // Sender side: literal result for the pixel on the bus, if any.
    logic   tx_known;
    pixel_t tx_literal;

    // Receiver side: random ready, gated by the long hold-off counter.
    logic   rx_ready;
    logic   rx_hold_req;
    int     rx_hold_count;

    pixel_t expected_rgb [$];
    int     mismatches;
    int     beats_seen;
    string  channel_name [3] = '{"red", "green", "blue"};

    assign m_axis_tready = rx_ready && (rx_hold_count == 0);

    oklab_to_linear_srgb uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Decimal times 1e10 to signed Q(MAT_FRAC), magnitude rounded half up.
    // Split into whole and fraction so the shift never overflows 64 bits.
    function automatic longint dec_to_q(input longint dec);
        longint unsigned mag;
        longint unsigned whole;
        longint unsigned frac;
        mag   = (dec < 0) ? -dec : dec;
        whole = mag / 64'd10000000000;
        frac  = mag % 64'd10000000000;
        mag   = (whole << MAT_FRAC) + ((frac << MAT_FRAC) + 64'd5000000000) / 64'd10000000000;
        return (dec < 0) ? -$signed(mag) : $signed(mag);
    endfunction

    // Round to nearest, ties toward plus infinity; >>> floors on signed values.
    function automatic longint round_q(input longint v, input int sh);
        return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    // Expected linear sRGB for one Oklab pixel.
    function automatic pixel_t oklab_to_rgb(input pixel_t pix);
        longint lum;
        longint ax;
        longint bx;
        longint acc;
        longint p;
        longint cone [3];
        pixel_t rgb;
        lum = longint'($signed(pix[0]));
        ax  = longint'($signed(pix[1]));
        bx  = longint'($signed(pix[2]));
        for (int i = 0; i < 3; i++) begin
            acc = (lum <<< MAT_FRAC) + dec_to_q(CONE_DEC[i][0]) * ax
                + dec_to_q(CONE_DEC[i][1]) * bx;
            p = round_q(acc, MAT_FRAC);
            cone[i] = round_q(p * p * p, 2 * PIX_FRAC);
        end
        for (int i = 0; i < 3; i++) begin
            acc = dec_to_q(RGB_DEC[i][0]) * cone[0] + dec_to_q(RGB_DEC[i][1]) * cone[1]
                + dec_to_q(RGB_DEC[i][2]) * cone[2];
            acc = round_q(acc, MAT_FRAC);
            if (acc > 32767) begin
                acc = 32767;
            end else if (acc < -32768) begin
                acc = -32768;
            end
            rgb[i] = acc[15:0];
        end
        return rgb;
    endfunction

    // Mostly natural colors; the rest full-range noise and extreme mixes.
    function automatic pixel_t random_pixel();
        pixel_t pix;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
                pix[0] = 16'($urandom_range(0, 16384));
                pix[1] = 16'(int'($urandom_range(0, 13108)) - 6554);
                pix[2] = 16'(int'($urandom_range(0, 13108)) - 6554);
            end
            6, 7: begin
                pix = {16'($urandom), 16'($urandom), 16'($urandom)};
            end
            8: begin
                pix[0] = 16'(int'($urandom_range(0, 32768)) - 8192);
                pix[1] = 16'(int'($urandom_range(0, 32768)) - 16384);
                pix[2] = 16'(int'($urandom_range(0, 32768)) - 16384);
            end
            default: begin
                for (int i = 0; i < 3; i++) begin
                    case ($urandom_range(0, 3))
                        0:       pix[i] = 16'h7FFF;
                        1:       pix[i] = 16'h8000;
                        2:       pix[i] = 16'h0000;
                        default: pix[i] = 16'($urandom);
                    endcase
                end
            end
        endcase
        return pix;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatches++;
    endtask

    // Offer one pixel after gap idle cycles and hold it until accepted.
    // Enter and leave at a falling edge; tvalid stays high across a zero gap.
    task automatic drive_pixel(input pixel_t pix, input logic known, input pixel_t literal,
                               input int gap);
        repeat (gap) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        tx_known      <= known;
        tx_literal    <= literal;
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
    endtask

    // Stop offering and wait until every pending result has come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(negedge aclk);
        while (expected_rgb.size() != 0) @(negedge aclk);
    endtask

    // Scoreboard: check the output beat first, then record the input beat.
    always @(posedge aclk) begin : scoreboard
        pixel_t want;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                beats_seen++;
                if (expected_rgb.size() == 0) begin
                    report_mismatch($sformatf("output beat %0d with no pixel pending: %h",
                                              beats_seen, m_axis_tdata));
                end else begin
                    want = expected_rgb.pop_front();
                    for (int i = 0; i < 3; i++) begin
                        if (m_axis_tdata[i] !== want[i]) begin
                            report_mismatch($sformatf("beat %0d %s got %0d want %0d",
                                beats_seen, channel_name[i], $signed(m_axis_tdata[i]),
                                $signed(want[i])));
                        end
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                expected_rgb.push_back(tx_known ? tx_literal : oklab_to_rgb(s_axis_tdata));
            end
        end
    end

    // Long hold-off: count it here so the sender keeps pushing meanwhile.
    // The request is raised at a rising edge and taken at the next falling one.
    always @(negedge aclk) begin
        if (rx_hold_req) begin
            rx_hold_req = 1'b0;
            rx_hold_count <= RX_HOLD;
        end else if (rx_hold_count != 0) begin
            rx_hold_count <= rx_hold_count - 1;
        end
    end

    // Receiver: idle a random number of cycles before each beat, with
    // occasional stretches of always-ready.
    initial begin : receiver
        int wait_cycles;
        int served;
        bit rx_burst;
        rx_ready = 1'b0;
        served   = 0;
        rx_burst = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if (served % 32 == 0) begin
                rx_burst = ($urandom_range(0, 3) == 0);
            end
            wait_cycles = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (wait_cycles != 0) begin
                rx_ready <= 1'b0;
                repeat (wait_cycles) @(negedge aclk);
            end
            rx_ready <= 1'b1;
            do @(posedge aclk); while (!(m_axis_tvalid && m_axis_tready));
            @(negedge aclk);
            served++;
        end
    end

    // Stimulus and final verdict.
    initial begin : stimulus
        bit tx_burst;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        tx_known      = 1'b0;
        tx_literal    = '0;
        rx_hold_req   = 1'b0;
        rx_hold_count = 0;
        mismatches    = 0;
        beats_seen    = 0;
        tx_burst      = 1'b0;

        // Hold reset low, then release it at a falling edge.
        aresetn = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed table.
        foreach (DIRECTED[n]) begin
            drive_pixel({DIRECTED[n].b, DIRECTED[n].a, DIRECTED[n].l}, DIRECTED[n].known,
                        {DIRECTED[n].blue, DIRECTED[n].green, DIRECTED[n].red},
                        $urandom_range(0, MAX_GAP));
        end

        // Drain, then stall the receiver and stream back to back so the
        // pipeline fills and drops s_axis_tready.
        drain_results();
        @(posedge aclk);
        rx_hold_req = 1'b1;
        @(negedge aclk);
        for (int n = 0; n < BURST_ITEMS; n++) begin
            drive_pixel(random_pixel(), 1'b0, '0, 0);
        end
        drain_results();

        // Random pixels, switching between idling and back-to-back segments.
        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n % BURST_ITEMS == 0) begin
                tx_burst = ($urandom_range(0, 3) == 0);
            end
            if (n == NUM_RANDOM / 2) begin
                drain_results();
            end
            drive_pixel(random_pixel(), 1'b0, '0, tx_burst ? 0 : $urandom_range(0, MAX_GAP));
        end

        // Wait out the pipeline, then watch for stray beats.
        drain_results();
        repeat (TAIL_CYCLES) @(negedge aclk);

        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin : watchdog
        #5_000_000;
        $display("ERROR: timeout with %0d pixels pending", expected_rgb.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule : tb_top
